FILE: hdl/sobel_edge_magnitude_assert.svh
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_assert.svh
// Assertion macros shared by the edge magnitude RTL.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Widths, limits, register codes and shared types of the edge magnitude block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;
  localparam int MAG_LIMIT  = 255;

  localparam int PIX_W    = 8;
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int GRAD_W   = 12;   // signed gradient sum
  localparam int ABS_W    = 10;   // |G| <= 1020
  localparam int SQ_W     = 2 * ABS_W;
  localparam int SUM_W    = SQ_W + 1;
  localparam int ROOT_W   = 8;
  localparam int BIT_W    = $clog2(ROOT_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HEIGHT_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

  function automatic logic signed [GRAD_W-1:0] pix_ext(input logic [PIX_W-1:0] v);
    return $signed({{(GRAD_W-PIX_W){1'b0}}, v});
  endfunction

  function automatic logic [ABS_W-1:0] grad_abs(input logic signed [GRAD_W-1:0] g);
    logic signed [GRAD_W-1:0] a;
    a = g[GRAD_W-1] ? -g : g;
    return a[ABS_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over the red channel of a frame.
// ----------------------------------------------------------------------------
// Input: one 8-bit red_sample per word on in_valid/in_ready, raster order.
// Output: edge_magnitude plus row_end/frame_end on out_valid/out_ready, one
//   word per interior pixel, so the output frame is (width-2) x (height-2).
// Config: cfg_wr_en/cfg_index/cfg_data write frame_width (0) or frame_height
//   (1); a write to either restarts the frame at its top left pixel. Write only idle.
// Flow: one word at a time. A border pixel goes through accept, then line
//   store read and update. An interior pixel goes through accept, read,
//   squaring, root start, 8 steps of the bit-serial square root plus the
//   done cycle, then the load of the output register. When Gx^2+Gy^2
//   reaches 256^2 the root saturates without stepping.
// Stall: the output register holds a finished word; the next pixel is
//   accepted meanwhile and only waits at the output load if still full.
// Reset: counters, window and out_valid clear; width 640, height 480. The line
//   stores are not cleared: entries read before written never reach a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sobel_edge_magnitude_assert.svh"

module sobel_edge_magnitude (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [sem_pkg::PIX_W-1:0]      red_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [sem_pkg::ROOT_W-1:0]     edge_magnitude,
  output logic                                row_end,
  output logic                                frame_end,
  input  wire logic                           cfg_wr_en,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_START  = 3'd3;
  localparam logic [2:0] ST_ROOT   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]                      state;
  logic [sem_pkg::WIDTH_W-1:0]     frame_width;
  logic [sem_pkg::HEIGHT_W-1:0]    frame_height;
  logic [sem_pkg::ADDR_W-1:0]      column_count;
  logic [sem_pkg::ROW_W-1:0]       row_count;
  logic [sem_pkg::PIX_W-1:0]       window_regs [6];
  logic [sem_pkg::PIX_W-1:0]       bot;
  logic [sem_pkg::ABS_W-1:0]       gx_abs;
  logic [sem_pkg::ABS_W-1:0]       gy_abs;
  logic [sem_pkg::SQ_W-1:0]        sq_x;
  logic [sem_pkg::SQ_W-1:0]        sq_y;
  logic                            res_row_end;
  logic                            res_frame_end;

  logic [sem_pkg::WIDTH_W-1:0]     eff_width;
  logic [sem_pkg::HEIGHT_W-1:0]    eff_height;
  logic                            col_last;
  logic                            row_last;
  logic                            accept;
  logic                            interior;
  logic [sem_pkg::PIX_W-1:0]       top;
  logic [sem_pkg::PIX_W-1:0]       mid;
  logic signed [sem_pkg::GRAD_W-1:0] gx;
  logic signed [sem_pkg::GRAD_W-1:0] gy;
  logic                            line_wr;
  logic                            out_free;
  logic [sem_pkg::SUM_W-1:0]       sum_sq;
  sem_pkg::sqrt_status_t           sqrt_status;
  logic [sem_pkg::ROOT_W-1:0]      sqrt_root;

  // register values outside the legal range act as the nearest limit
  always_comb begin
    if (frame_width < sem_pkg::WIDTH_W'(sem_pkg::MIN_DIM)) begin
      eff_width = sem_pkg::WIDTH_W'(sem_pkg::MIN_DIM);
    end else if (frame_width > sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH)) begin
      eff_width = sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH);
    end else begin
      eff_width = frame_width;
    end
    if (frame_height < sem_pkg::HEIGHT_W'(sem_pkg::MIN_DIM)) begin
      eff_height = sem_pkg::HEIGHT_W'(sem_pkg::MIN_DIM);
    end else if (frame_height > sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT)) begin
      eff_height = sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      eff_height = frame_height;
    end
  end

  assign col_last = (sem_pkg::WIDTH_W'(column_count) == eff_width - 1'b1);
  assign row_last = (sem_pkg::HEIGHT_W'(row_count) == eff_height - 1'b1);
  assign interior = (row_count >= sem_pkg::ROW_W'(2)) && (column_count >= sem_pkg::ADDR_W'(2));

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign line_wr  = (state == ST_READ);
  assign out_free = !out_valid || out_ready;
  assign sum_sq   = sem_pkg::SUM_W'(sq_x) + sem_pkg::SUM_W'(sq_y);

  always_comb begin
    gx = sem_pkg::pix_ext(top) - sem_pkg::pix_ext(window_regs[0])
       + ((sem_pkg::pix_ext(mid) - sem_pkg::pix_ext(window_regs[2])) <<< 1)
       + sem_pkg::pix_ext(bot) - sem_pkg::pix_ext(window_regs[4]);
    gy = sem_pkg::pix_ext(window_regs[4]) - sem_pkg::pix_ext(window_regs[0])
       + ((sem_pkg::pix_ext(window_regs[5]) - sem_pkg::pix_ext(window_regs[1])) <<< 1)
       + sem_pkg::pix_ext(bot) - sem_pkg::pix_ext(top);
  end

  // both stores are read at the accepting edge and rewritten in the read state that follows
  sem_ram #(
    .WIDTH (sem_pkg::PIX_W),
    .DEPTH (sem_pkg::MAX_WIDTH)
  ) u_upper_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (column_count),
    .wr_data (mid),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (top)
  );

  sem_ram #(
    .WIDTH (sem_pkg::PIX_W),
    .DEPTH (sem_pkg::MAX_WIDTH)
  ) u_middle_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (column_count),
    .wr_data (bot),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (mid)
  );

  sem_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_START),
    .operand (sum_sq),
    .status  (sqrt_status),
    .root    (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frame_width   <= sem_pkg::WIDTH_RESET;
      frame_height  <= sem_pkg::HEIGHT_RESET;
      column_count  <= '0;
      row_count     <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        window_regs[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            bot   <= red_sample;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          gx_abs        <= sem_pkg::grad_abs(gx);
          gy_abs        <= sem_pkg::grad_abs(gy);
          res_row_end   <= col_last;
          res_frame_end <= col_last && row_last;
          window_regs[0] <= window_regs[1];
          window_regs[1] <= top;
          window_regs[2] <= window_regs[3];
          window_regs[3] <= mid;
          window_regs[4] <= window_regs[5];
          window_regs[5] <= bot;
          if (col_last) begin
            column_count <= '0;
            row_count    <= row_last ? '0 : row_count + 1'b1;
          end else begin
            column_count <= column_count + 1'b1;
          end
          state <= interior ? ST_SQUARE : ST_IDLE;
        end
        ST_SQUARE: begin
          sq_x  <= gx_abs * gx_abs;
          sq_y  <= gy_abs * gy_abs;
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sqrt_status.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            edge_magnitude <= sqrt_root;
            row_end        <= res_row_end;
            frame_end      <= res_frame_end;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // a register write restarts the frame
      if (cfg_wr_en) begin
        if (cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
          frame_width  <= cfg_data[sem_pkg::WIDTH_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end else if (cfg_index == sem_pkg::REG_FRAME_HEIGHT) begin
          frame_height <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
      end
    end
  end

  `SEM_ASSERT_NOW(a_idle_sqrt_quiet, state == ST_IDLE, !sqrt_status.busy, "sqrt busy while idle")
  `SEM_ASSERT_NOW(a_done_in_root, sqrt_status.done, state == ST_ROOT, "sqrt done outside root wait")
  `SEM_ASSERT_NOW(a_frame_end_row_end, out_valid && frame_end, row_end, "frame end without row end")
  `SEM_ASSERT_NEXT(a_accept_reads, accept, state == ST_READ, "accepted word not read next cycle")

endmodule

`default_nettype wire

FILE: hdl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sem_sqrt.sv
// ----------------------------------------------------------------------------
// sem_sqrt
// Bit-serial integer square root, one result bit per cycle, saturated at 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sem_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [sem_pkg::SUM_W-1:0]  operand,
  output sem_pkg::sqrt_status_t           status,
  output logic      [sem_pkg::ROOT_W-1:0] root
);

  localparam int REM_W = 2 * sem_pkg::ROOT_W;

  logic                        busy;
  logic                        done;
  logic [sem_pkg::BIT_W-1:0]   bit_idx;
  logic [REM_W-1:0]            radicand;
  logic [sem_pkg::ROOT_W-1:0]  trial;
  logic [REM_W-1:0]            trial_sq;

  always_comb begin
    trial    = root | (sem_pkg::ROOT_W'(1) << bit_idx);
    trial_sq = trial * trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_idx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // anything at or above 256^2 saturates without iterating
        if (operand[sem_pkg::SUM_W-1:REM_W] != '0) begin
          root <= sem_pkg::ROOT_W'(sem_pkg::MAG_LIMIT);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          radicand <= operand[REM_W-1:0];
          root     <= '0;
          bit_idx  <= sem_pkg::BIT_W'(sem_pkg::ROOT_W - 1);
          busy     <= 1'b1;
        end
      end else if (busy) begin
        if (trial_sq <= radicand) begin
          root <= trial;
        end
        if (bit_idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

FILE: tb/tb_sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude
// Self-checking bench for the streaming Sobel edge magnitude block. Red
// samples go in through a bursty valid/ready driver, and the edge words
// coming out under random backpressure are checked field by field against an
// in-bench line-store and window predictor. The run covers a short stretch at
// the reset geometry, small frames, the out-of-range geometry at the low end
// (width and height clamping), dropped bits above the width field and
// restarts on register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;
  import sem_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int RESET_ITEMS   = 40;

  // indexes outside the register map: writes there change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [PIX_W-1:0] sample;
    bit               drain_first;  // hold off until all edge words are back
  } pixel_item_t;

  typedef struct {
    logic [ROOT_W-1:0] magnitude;
    logic              row_end;
    logic              frame_end;
  } edge_word_t;

  typedef enum int {READY_STEADY, READY_COIN, READY_CHOKE} ready_mode_e;
  typedef enum int {FILL_NOISE, FILL_RAMP, FILL_BINARY, FILL_FLAT} fill_mode_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      red_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROOT_W-1:0]     edge_magnitude;
  logic                  row_end;
  logic                  frame_end;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_item_t pixel_q[$];
  edge_word_t  pending_edges[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // driver and receiver pacing
  int          burst_left = 1;
  int          gap_left = 0;
  ready_mode_e ready_mode = READY_STEADY;
  int          mode_left = 0;
  int          ready_left = 0;

  // predictor state
  logic [PIX_W-1:0]    upper_row [MAX_WIDTH];
  logic [PIX_W-1:0]    middle_row [MAX_WIDTH];
  logic [PIX_W-1:0]    win_top [2] = '{default: '0};  // [0] is column c-2
  logic [PIX_W-1:0]    win_mid [2] = '{default: '0};
  logic [PIX_W-1:0]    win_bot [2] = '{default: '0};
  int                  col_pos = 0;
  int                  row_pos = 0;
  logic [WIDTH_W-1:0]  width_shadow = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_shadow = HEIGHT_RESET;

  // three 3x3 frames: a small exact root, a saturated -Gx, and Gx=255, Gy=-1
  logic [PIX_W-1:0] directed_pixels [27] = '{
    8'd0,   8'd0, 8'd0,   8'd0,   8'd0, 8'd1, 8'd0,   8'd0, 8'd6,
    8'd255, 8'd0, 8'd0,   8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
    8'd0,   8'd0, 8'd128, 8'd0,   8'd0, 8'd0, 8'd0,   8'd0, 8'd127
  };

  sobel_edge_magnitude i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .red_sample     (red_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edge_magnitude (edge_magnitude),
    .row_end        (row_end),
    .frame_end      (frame_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [ROOT_W-1:0] sat_isqrt(input int unsigned sq);
    int unsigned root;
    root = 0;
    if (sq >= (MAG_LIMIT + 1) * (MAG_LIMIT + 1)) begin
      root = MAG_LIMIT;
    end else begin
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        if ((root + (1 << b)) * (root + (1 << b)) <= sq) root += (1 << b);
      end
    end
    return root[ROOT_W-1:0];
  endfunction

  // one accepted pixel: slide the window and line stores, queue a word if interior
  task automatic predict_edge_word(input logic [PIX_W-1:0] px);
    int               w;
    int               h;
    int               c;
    int               r;
    int               gx;
    int               gy;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    edge_word_t       word;
    w = clamp_dim(int'(width_shadow), MAX_WIDTH);
    h = clamp_dim(int'(height_shadow), MAX_HEIGHT);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    top = upper_row[c];
    mid = middle_row[c];
    if (r >= 2 && c >= 2) begin
      gx = int'(top) - int'(win_top[0]) + 2 * (int'(mid) - int'(win_mid[0]))
           + int'(px) - int'(win_bot[0]);
      gy = int'(px) + 2 * int'(win_bot[1]) + int'(win_bot[0])
           - int'(win_top[0]) - 2 * int'(win_top[1]) - int'(top);
      word.magnitude = sat_isqrt(gx * gx + gy * gy);
      word.row_end   = (c == w - 1);
      word.frame_end = (c == w - 1) && (r == h - 1);
      pending_edges.push_back(word);
    end
    win_top[0] = win_top[1]; win_top[1] = top;
    win_mid[0] = win_mid[1]; win_mid[1] = mid;
    win_bot[0] = win_bot[1]; win_bot[1] = px;
    upper_row[c]  = mid;
    middle_row[c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      if (idx == REG_FRAME_WIDTH) width_shadow = value[WIDTH_W-1:0];
      else height_shadow = value[HEIGHT_W-1:0];
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  // sampled between edges, once the driver and monitor have settled
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pixel_q.size() != 0 || in_valid || pending_edges.size() != 0);
    // border pixels leave no word behind but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixels(input int count, input int w_eff, input bit drain_once);
    fill_mode_e  mode;
    int          base;
    int          slope_x;
    int          slope_y;
    int          v;
    int          drain_at;
    pixel_item_t item;
    mode     = fill_mode_e'($urandom_range(0, 3));
    base     = $urandom_range(0, 255);
    slope_x  = $urandom_range(0, 80);
    slope_x -= 40;
    slope_y  = $urandom_range(0, 80);
    slope_y -= 40;
    drain_at = drain_once ? $urandom_range(1, count - 1) : -1;
    for (int k = 0; k < count; k++) begin
      case (mode)
        FILL_NOISE:  v = $urandom_range(0, 255);
        FILL_RAMP: begin
          v = base + slope_x * (k % w_eff) + slope_y * ((k / w_eff) % 8);
          v = v + $urandom_range(0, 6) - 3;
        end
        FILL_BINARY: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
        default:     v = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : base;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      item.sample      = v[PIX_W-1:0];
      item.drain_first = (k == drain_at);
      pixel_q.push_back(item);
    end
  endtask

  initial begin : clock_gen
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin : drive_pixels
    pixel_item_t item;
    logic        next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        predict_edge_word(red_sample);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0 &&
                     !(pixel_q[0].drain_first && pending_edges.size() != 0)) begin
          item = pixel_q.pop_front();
          red_sample <= item.sample;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin : check_edges
    edge_word_t want;
    logic       next_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_edges.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual mag=%0d row_end=%0b frame_end=%0b",
                   $time, edge_magnitude, row_end, frame_end);
          mismatch_count++;
        end else begin
          want = pending_edges.pop_front();
          if ({edge_magnitude, row_end, frame_end} !==
              {want.magnitude, want.row_end, want.frame_end}) begin
            $display("%0t: word mismatch, expected mag=%0d row_end=%0b frame_end=%0b, actual mag=%0d row_end=%0b frame_end=%0b",
                     $time, want.magnitude, want.row_end, want.frame_end,
                     edge_magnitude, row_end, frame_end);
            mismatch_count++;
          end
        end
      end
      if (ready_left > 0) begin
        ready_left--;
        next_ready = out_ready;
      end else begin
        case (ready_mode)
          READY_STEADY: begin
            next_ready = 1'b1;
            ready_left = $urandom_range(10, 60);
          end
          READY_COIN: begin
            next_ready = ($urandom_range(0, 1) == 1);
            ready_left = $urandom_range(0, 2);
          end
          default: begin
            next_ready = !out_ready;
            ready_left = next_ready ? $urandom_range(0, 3) : $urandom_range(1, 24);
          end
        endcase
      end
      if (mode_left > 0) begin
        mode_left--;
      end else begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(50, 400);
      end
      out_ready <= next_ready;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sobel_edge_magnitude: done, errors");
    $finish;
  end

  initial begin : stimulus
    int          w_val;
    int          h_val;
    int          w_eff;
    int          h_eff;
    int          count;
    int          random_sent;
    int          phase;
    pixel_item_t item;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: part of the first row, no word may come out
    queue_pixels(RESET_ITEMS, int'(WIDTH_RESET), 1'b0);
    wait_drained();

    // directed 3x3 frames; width 0 and height 1 both clamp up to 3
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 1);
    foreach (directed_pixels[i]) begin
      item.sample      = directed_pixels[i];
      item.drain_first = 1'b0;
      pixel_q.push_back(item);
    end
    wait_drained();

    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_val = $urandom_range(0, 2);
        1:       w_val = $urandom_range(13, 64);
        2:       w_val = 32'h1800 | $urandom_range(3, 12);  // bits above the field drop
        default: w_val = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h_val = $urandom_range(0, 2);
        1:       h_val = $urandom_range(9, 20);
        default: h_val = $urandom_range(3, 8);
      endcase
      case ((phase == 0) ? 2 : $urandom_range(0, 3))
        0:       write_reg(REG_FRAME_WIDTH, w_val);
        1:       write_reg(REG_FRAME_HEIGHT, h_val);
        default: begin
          write_reg(REG_FRAME_WIDTH, w_val);
          write_reg(REG_FRAME_HEIGHT, h_val);
        end
      endcase
      w_eff = clamp_dim(int'(width_shadow), MAX_WIDTH);
      h_eff = clamp_dim(int'(height_shadow), MAX_HEIGHT);
      // whole frames plus a partial one, so the next write can land mid-frame
      count = $urandom_range(1, 3) * w_eff * h_eff + $urandom_range(0, w_eff * h_eff - 1);
      if (count > 400) count = $urandom_range(3 * w_eff, 400);
      queue_pixels(count, w_eff, phase == 0 || $urandom_range(0, 3) == 0);
      random_sent += count;
      wait_drained();
      // unmapped index: the frame must carry on where it was
      if ($urandom_range(0, 4) == 0) begin
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        count = 2 * w_eff + $urandom_range(1, w_eff * h_eff);
        if (count > 400) count = $urandom_range(2 * w_eff + 1, 400);
        queue_pixels(count, w_eff, 1'b0);
        random_sent += count;
        wait_drained();
      end
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("tb_sobel_edge_magnitude: done, clean");
    end else begin
      $display("tb_sobel_edge_magnitude: done, errors");
    end
    $finish;
  end

endmodule
